### src/bscu_pkg.sv
// Shared types and constants of the barometric sensor compensation unit.
// Used by every module of the block; depends on nothing.
package bscu_pkg;

    // Field and datapath widths
    localparam int RawW     = 24;
    localparam int CoefW    = 16;
    localparam int DtW      = 25;
    localparam int MulAW    = 34;
    localparam int MulBW    = 24;
    localparam int ProdW    = MulAW + MulBW + 1;
    localparam int TempW    = 19;
    localparam int PresW    = 23;
    localparam int OffW     = 35;
    localparam int SensW    = 34;
    localparam int DiffW    = 38;
    localparam int CntW     = 5;
    localparam int OutDataW = 48;

    // Multiplier pass lengths in bits of the multiplier operand
    localparam int ShortLen = 16;
    localparam int LongLen  = 24;

    localparam logic [TempW-1:0] TEMP_BASE = 19'd2000;

    // Configuration port
    localparam int ApbAw   = 5;
    localparam int ApbDw   = 32;
    localparam int RegIdxW = 3;

    localparam logic [RegIdxW-1:0] REG_SENS_BASE     = 3'd0;
    localparam logic [RegIdxW-1:0] REG_OFFSET_BASE   = 3'd1;
    localparam logic [RegIdxW-1:0] REG_SENS_TEMPCO   = 3'd2;
    localparam logic [RegIdxW-1:0] REG_OFFSET_TEMPCO = 3'd3;
    localparam logic [RegIdxW-1:0] REG_REF_TEMP      = 3'd4;
    localparam logic [RegIdxW-1:0] REG_TEMP_SLOPE    = 3'd5;

    typedef struct packed {
        logic [CoefW-1:0] sens_base;
        logic [CoefW-1:0] offset_base;
        logic [CoefW-1:0] sens_tempco;
        logic [CoefW-1:0] offset_tempco;
        logic [CoefW-1:0] ref_temp;
        logic [CoefW-1:0] temp_slope;
    } coef_t;

    typedef struct packed {
        logic start;
        logic short_op;
    } mul_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

endpackage

### src/bscu_cfg_regs.sv
// APB-style register file holding the six calibration coefficients.
// Depends on bscu_pkg.
module bscu_cfg_regs
    import bscu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [ApbAw-1:0] paddr,
    input  logic [ApbDw-1:0] pwdata,
    output logic [ApbDw-1:0] prdata,
    output logic             pready,
    output coef_t            coef
);

    coef_t              coef_reg;
    coef_t              coef_next;
    logic               wr_en;
    logic [RegIdxW-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[ApbAw-1:2];
    assign coef   = coef_reg;

    // Decode the write beat; addresses past the list are dropped
    always_comb
    begin
        coef_next = coef_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_SENS_BASE:     coef_next.sens_base     = pwdata[CoefW-1:0];
                REG_OFFSET_BASE:   coef_next.offset_base   = pwdata[CoefW-1:0];
                REG_SENS_TEMPCO:   coef_next.sens_tempco   = pwdata[CoefW-1:0];
                REG_OFFSET_TEMPCO: coef_next.offset_tempco = pwdata[CoefW-1:0];
                REG_REF_TEMP:      coef_next.ref_temp      = pwdata[CoefW-1:0];
                REG_TEMP_SLOPE:    coef_next.temp_slope    = pwdata[CoefW-1:0];
                default:           coef_next = coef_reg;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (idx)
            REG_SENS_BASE:     prdata = {16'h0, coef_reg.sens_base};
            REG_OFFSET_BASE:   prdata = {16'h0, coef_reg.offset_base};
            REG_SENS_TEMPCO:   prdata = {16'h0, coef_reg.sens_tempco};
            REG_OFFSET_TEMPCO: prdata = {16'h0, coef_reg.offset_tempco};
            REG_REF_TEMP:      prdata = {16'h0, coef_reg.ref_temp};
            REG_TEMP_SLOPE:    prdata = {16'h0, coef_reg.temp_slope};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

endmodule

### src/bscu_serial_mult.sv
// Bit-serial shift-add multiplier: signed multiplicand times unsigned multiplier,
// one multiplier bit per cycle. Depends on bscu_pkg.
module bscu_serial_mult
    import bscu_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mul_ctrl_t               ctrl,
    input  logic [MulAW-1:0]        mcand,
    input  logic [MulBW-1:0]        mplier,
    output logic signed [ProdW-1:0] product,
    output mul_stat_t               stat
);

    logic [MulAW-1:0] mcand_reg,  mcand_next;
    logic [MulAW:0]   acc_reg,    acc_next;
    logic [MulBW-1:0] mplier_reg, mplier_next;
    logic [CntW-1:0]  cnt_reg,    cnt_next;
    logic             busy_reg,   busy_next;
    logic             done_reg,   done_next;
    logic             short_reg,  short_next;
    logic [MulAW:0]   addend;
    logic [MulAW:0]   sum;

    // Add the multiplicand when the current multiplier bit is set
    assign addend = mplier_reg[0] ? {mcand_reg[MulAW-1], mcand_reg} : '0;
    assign sum    = acc_reg + addend;

    // Load on start, else shift the partial product one bit right per cycle while busy
    always_comb
    begin
        mcand_next  = mcand_reg;
        acc_next    = acc_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        short_next  = short_reg;
        done_next   = 1'b0;
        if (ctrl.start)
        begin
            mcand_next  = mcand;
            acc_next    = '0;
            mplier_next = mplier;
            cnt_next    = ctrl.short_op ? CntW'(ShortLen) : CntW'(LongLen);
            busy_next   = 1'b1;
            short_next  = ctrl.short_op;
        end
        else if (busy_reg)
        begin
            acc_next    = {sum[MulAW], sum[MulAW:1]};
            mplier_next = {sum[0], mplier_reg[MulBW-1:1]};
            cnt_next    = cnt_reg - CntW'(1);
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // A short pass leaves its low product bits in the top of the multiplier register
    assign product = short_reg
        ? {{(LongLen - ShortLen){acc_reg[MulAW]}}, acc_reg,
           mplier_reg[MulBW-1:LongLen-ShortLen]}
        : {acc_reg, mplier_reg};

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        acc_reg    <= acc_next;
        mplier_reg <= mplier_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            short_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            short_reg <= short_next;
        end
    end

endmodule

### src/bscu_core.sv
// Sequencer of the compensation: pairs raw words, runs the four products
// through the serial multiplier and holds the result beat. Depends on bscu_pkg.
module bscu_core
    import bscu_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  coef_t                   coef,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [RawW-1:0]         s_tdata,     // [23:0] raw_word
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OutDataW-1:0]     m_tdata,     // [18:0] temp_centi, [41:19] pressure_comp
    output mul_ctrl_t               mul_ctrl,
    output logic [MulAW-1:0]        mcand,
    output logic [MulBW-1:0]        mplier,
    input  logic signed [ProdW-1:0] product,
    input  mul_stat_t               mul_stat
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL_T = 3'd1;
    localparam logic [2:0] ST_MUL_O = 3'd2;
    localparam logic [2:0] ST_MUL_S = 3'd3;
    localparam logic [2:0] ST_MUL_P = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]       state_reg,       state_next;
    logic             expect_temp_reg, expect_temp_next;
    logic             out_valid_reg,   out_valid_next;
    logic [RawW-1:0]  held_raw_reg,    held_raw_next;
    logic [DtW-1:0]   dt_reg,          dt_next;
    logic [TempW-1:0] temp_reg,        temp_next;
    logic [OffW-1:0]  off_reg,         off_next;
    logic [PresW-1:0] pres_reg,        pres_next;
    logic [TempW-1:0] out_temp_reg,    out_temp_next;
    logic [PresW-1:0] out_pres_reg,    out_pres_next;

    logic             accept;
    logic [DtW-1:0]   dt_new;
    logic [TempW-1:0] temp_calc;
    logic [OffW-1:0]  off_calc;
    logic [SensW-1:0] sens_calc;
    logic [DiffW-1:0] diff;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Post-multiply arithmetic; each product is exact, so fixed slices do the floor shifts
    assign dt_new    = {1'b0, s_tdata} - {1'b0, coef.ref_temp, 8'h00};
    assign temp_calc = product[41:23] + TEMP_BASE;
    assign off_calc  = product[41:7] + {3'b000, coef.offset_base, 16'h0000};
    assign sens_calc = product[41:8] + {3'b000, coef.sens_base, 15'h0000};
    assign diff      = product[ProdW-1:21] - {{(DiffW - OffW){off_reg[OffW-1]}}, off_reg};

    // Step through temperature, offset, sensitivity and pressure products
    always_comb
    begin
        state_next       = state_reg;
        expect_temp_next = expect_temp_reg;
        held_raw_next    = held_raw_reg;
        dt_next          = dt_reg;
        temp_next        = temp_reg;
        off_next         = off_reg;
        pres_next        = pres_reg;
        out_temp_next    = out_temp_reg;
        out_pres_next    = out_pres_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        mul_ctrl.start    = 1'b0;
        mul_ctrl.short_op = 1'b1;
        mcand             = {{(MulAW - DtW){dt_reg[DtW-1]}}, dt_reg};
        mplier            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!expect_temp_reg)
                    begin
                        held_raw_next    = s_tdata;
                        expect_temp_next = 1'b1;
                    end
                    else
                    begin
                        expect_temp_next = 1'b0;
                        dt_next          = dt_new;
                        mul_ctrl.start   = 1'b1;
                        mcand            = {{(MulAW - DtW){dt_new[DtW-1]}}, dt_new};
                        mplier           = {8'h00, coef.temp_slope};
                        state_next       = ST_MUL_T;
                    end
                end
            end
            ST_MUL_T:
            begin
                mplier = {8'h00, coef.offset_tempco};
                if (mul_stat.done)
                begin
                    temp_next      = temp_calc;
                    mul_ctrl.start = 1'b1;
                    state_next     = ST_MUL_O;
                end
            end
            ST_MUL_O:
            begin
                mplier = {8'h00, coef.sens_tempco};
                if (mul_stat.done)
                begin
                    off_next       = off_calc;
                    mul_ctrl.start = 1'b1;
                    state_next     = ST_MUL_S;
                end
            end
            ST_MUL_S:
            begin
                mcand             = sens_calc;
                mplier            = held_raw_reg;
                mul_ctrl.short_op = 1'b0;
                if (mul_stat.done)
                begin
                    mul_ctrl.start = 1'b1;
                    state_next     = ST_MUL_P;
                end
            end
            ST_MUL_P:
            begin
                if (mul_stat.done)
                begin
                    pres_next  = diff[DiffW-1:15];
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_temp_next  = temp_reg;
                    out_pres_next  = pres_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OutDataW - TempW - PresW){1'b0}}, out_pres_reg, out_temp_reg};

    always_ff @(posedge clk)
    begin
        held_raw_reg <= held_raw_next;
        dt_reg       <= dt_next;
        temp_reg     <= temp_next;
        off_reg      <= off_next;
        pres_reg     <= pres_next;
        out_temp_reg <= out_temp_next;
        out_pres_reg <= out_pres_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            expect_temp_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            expect_temp_reg <= expect_temp_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        mul_ctrl.start |-> !mul_stat.busy)
        else $error("multiplier started while busy");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mul_stat.busy)
        else $error("multiplier busy while sequencer idle");

    a_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        mul_stat.done |-> (state_reg == ST_MUL_T || state_reg == ST_MUL_O ||
                           state_reg == ST_MUL_S || state_reg == ST_MUL_P))
        else $error("product finished outside a multiply step");

    a_pressure_held: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !expect_temp_reg) |=> (state_reg == ST_IDLE && expect_temp_reg))
        else $error("pressure beat did not arm the temperature slot");

endmodule

### src/baro_sensor_compensation_unit.sv
// Barometric sensor first-order compensation, top level.
// A pressure beat is held and gives no result. A temperature beat gives its result
// after three 16-bit passes and one 24-bit pass through the shared bit-serial
// multiplier, one multiplier bit per cycle, and a handoff to the result register.
// One pair is in flight at a time; the next beat is taken while a result waits. rst_n
// clears coefficients, alternation and result valid.
module baro_sensor_compensation_unit
    import bscu_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ApbAw-1:0]    paddr,
    input  logic [ApbDw-1:0]    pwdata,
    output logic [ApbDw-1:0]    prdata,
    output logic                pready,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [RawW-1:0]     s_tdata,     // [23:0] raw_word
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata      // [18:0] temp_centi, [41:19] pressure_comp
);

    coef_t                   coef;
    mul_ctrl_t               mul_ctrl;
    mul_stat_t               mul_stat;
    logic [MulAW-1:0]        mcand;
    logic [MulBW-1:0]        mplier;
    logic signed [ProdW-1:0] product;

    // Coefficient registers
    bscu_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    // Shared serial multiplier
    bscu_serial_mult u_serial_mult (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mul_ctrl),
        .mcand   (mcand),
        .mplier  (mplier),
        .product (product),
        .stat    (mul_stat)
    );

    // Sequencer and result register
    bscu_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .coef     (coef),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .mul_ctrl (mul_ctrl),
        .mcand    (mcand),
        .mplier   (mplier),
        .product  (product),
        .mul_stat (mul_stat)
    );

endmodule
